>>> hdl/vgs_pkg.sv
// ----------------------------------------------------------------------------
// vgs_pkg
// Shared constants, opcodes and helpers for the grid scan frame buffer.
// ----------------------------------------------------------------------------
package vgs_pkg;

   localparam int DEF_GRID_COLUMNS = 24;
   localparam int DEF_LINES        = 32;

   localparam int BITS_PER_COLUMN  = 6;
   localparam int LINES_PER_WORD   = 8;
   localparam int WORD_W           = 48;
   localparam int CHUNK_W          = 3;
   localparam int POS_W            = 6;
   localparam int X_W              = 8;
   localparam int Y_W              = 5;
   localparam int X_VALUES         = 256;

   localparam logic OP_PIXEL_WRITE = 1'b0;
   localparam logic OP_SCAN_TICK   = 1'b1;

   // anode bits lit on even and odd grid positions
   localparam logic [BITS_PER_COLUMN-1:0] KEEP_EVEN = 6'h15;
   localparam logic [BITS_PER_COLUMN-1:0] KEEP_ODD  = 6'h2A;

   // anode bit of a pixel within its column, by x mod 6
   function automatic logic [BITS_PER_COLUMN-1:0] pixel_mask(input int r);
      logic [BITS_PER_COLUMN-1:0] m;
      case (r)
         0:       m = 6'h01;
         1:       m = 6'h04;
         2:       m = 6'h10;
         3:       m = 6'h20;
         4:       m = 6'h08;
         5:       m = 6'h02;
         default: m = 6'h00;
      endcase
      return m;
   endfunction

endpackage

>>> hdl/vgs_store.sv
// ----------------------------------------------------------------------------
// vgs_store
// Single-port frame store with registered read data and a clearing pass
// after reset.
// ----------------------------------------------------------------------------
module vgs_store
   import vgs_pkg::*;
#(
   parameter int DEPTH  = DEF_LINES * DEF_GRID_COLUMNS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mem_en,
   input  logic                       mem_we,
   input  logic [ADDR_W-1:0]          mem_addr,
   input  logic [BITS_PER_COLUMN-1:0] mem_wdata,
   output logic [BITS_PER_COLUMN-1:0] mem_rdata,
   output logic                       clear_busy
);

   logic [BITS_PER_COLUMN-1:0] mem [DEPTH];
   logic [BITS_PER_COLUMN-1:0] rdata_ff;
   logic [ADDR_W-1:0]          clr_addr_ff;
   logic                       clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (mem_en && mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (!clr_busy_ff && mem_en && !mem_we) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign mem_rdata  = rdata_ff;
   assign clear_busy = clr_busy_ff;

endmodule

>>> hdl/vgs_pixmap.sv
// ----------------------------------------------------------------------------
// vgs_pixmap
// Maps a pixel coordinate to a frame store address and anode bit mask.
// ----------------------------------------------------------------------------
module vgs_pixmap
   import vgs_pkg::*;
#(
   parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
   parameter int LINES        = DEF_LINES
) (
   input  logic [X_W-1:0]                             pixel_x,
   input  logic [Y_W-1:0]                             pixel_y,
   output logic [$clog2(LINES*GRID_COLUMNS)-1:0]      pix_addr,
   output logic [BITS_PER_COLUMN-1:0]                 pix_mask,
   output logic                                       pix_ok
);

   localparam int ADDR_W = $clog2(LINES * GRID_COLUMNS);
   localparam int COL_W  = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;

   logic [COL_W-1:0]           col_lut  [X_VALUES];
   logic [BITS_PER_COLUMN-1:0] mask_lut [X_VALUES];

   // column and bit tables over every x value, built at elaboration
   for (genvar gi = 0; gi < X_VALUES; gi++) begin : g_lut
      assign col_lut[gi]  = COL_W'((gi / BITS_PER_COLUMN) % GRID_COLUMNS);
      assign mask_lut[gi] = pixel_mask(gi % BITS_PER_COLUMN);
   end

   assign pix_addr = ADDR_W'(pixel_y * GRID_COLUMNS + col_lut[pixel_x]);
   assign pix_mask = mask_lut[pixel_x];
   assign pix_ok   = {1'b0, pixel_y} < (Y_W + 1)'(LINES);

endmodule

>>> hdl/vgs_ctrl.sv
// ----------------------------------------------------------------------------
// vgs_ctrl
// Item sequencer: pixel read-modify-write, scan read stream, word
// assembly and the result register.
// ----------------------------------------------------------------------------
module vgs_ctrl
   import vgs_pkg::*;
#(
   parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
   parameter int LINES        = DEF_LINES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic                                  req_pixel_on,
   // mapped pixel
   input  logic [$clog2(LINES*GRID_COLUMNS)-1:0] pix_addr,
   input  logic [BITS_PER_COLUMN-1:0]            pix_mask,
   input  logic                                  pix_ok,
   // frame store port
   output logic                                  mem_en,
   output logic                                  mem_we,
   output logic [$clog2(LINES*GRID_COLUMNS)-1:0] mem_addr,
   output logic [BITS_PER_COLUMN-1:0]            mem_wdata,
   input  logic [BITS_PER_COLUMN-1:0]            mem_rdata,
   input  logic                                  clear_busy,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [WORD_W-1:0]                     rsp_shift_word,
   output logic [CHUNK_W-1:0]                    rsp_chunk_index,
   output logic                                  rsp_last_chunk
);

   localparam int ADDR_W     = $clog2(LINES * GRID_COLUMNS);
   localparam int LINE_W     = $clog2(LINES);
   localparam int LCNT_W     = $clog2(LINES + 1);
   localparam int DATA_WORDS = (LINES + LINES_PER_WORD - 1) / LINES_PER_WORD;
   localparam int POS_LIMIT  = 2 * GRID_COLUMNS - 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_RD,
      ST_WR_WB,
      ST_SCAN,
      ST_GRID
   } state_type;

   state_type                  state_ff;
   logic [ADDR_W-1:0]          wr_addr_ff;
   logic [BITS_PER_COLUMN-1:0] wr_mask_ff;
   logic                       wr_on_ff;
   logic [POS_W-1:0]           pos_ff;
   logic [LCNT_W-1:0]          rd_line_ff;
   logic                       rd_pend_ff;
   logic [LINE_W-1:0]          pend_line_ff;
   logic [WORD_W-1:0]          acc_ff;
   logic [WORD_W-1:0]          acc_in;
   logic                       acc_full_ff;
   logic [CHUNK_W-1:0]         acc_chunk_ff;
   logic                       rsp_valid_ff;
   logic [WORD_W-1:0]          rsp_word_ff;
   logic [CHUNK_W-1:0]         rsp_chunk_ff;
   logic                       rsp_last_ff;

   logic                       accept;
   logic                       out_free;
   logic                       acc_move;
   logic                       lines_left;
   logic                       pend_last;
   logic                       issue;
   logic                       scan_done;
   logic                       grid_load;
   logic [BITS_PER_COLUMN-1:0] keep;
   logic [POS_W:0]             pos_inc;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || clear_busy;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign acc_move   = acc_full_ff && out_free;
   assign lines_left = rd_line_ff < LCNT_W'(LINES);
   assign pend_last  = (pend_line_ff[2:0] == 3'd7) || (pend_line_ff == LINE_W'(LINES - 1));
   assign keep       = pos_ff[0] ? KEEP_ODD : KEEP_EVEN;

   // first line of a group waits until the previous word can leave the
   // accumulator by the time its data lands
   assign issue = (state_ff == ST_SCAN) && lines_left &&
                  !((rd_line_ff[2:0] == 3'd0) &&
                    ((acc_full_ff && !out_free) || (rd_pend_ff && pend_last)));

   assign scan_done = (state_ff == ST_SCAN) && !lines_left && !rd_pend_ff &&
                      (!acc_full_ff || out_free);
   assign grid_load = (state_ff == ST_GRID) && out_free;
   assign pos_inc   = {1'b0, pos_ff} + 1'b1;

   always_comb begin
      acc_in = acc_ff;
      if (pend_line_ff[2:0] == 3'd0) begin
         acc_in = '0;
      end
      acc_in[pend_line_ff[2:0] * BITS_PER_COLUMN +: BITS_PER_COLUMN] = mem_rdata & keep;
   end

   always_comb begin
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = wr_addr_ff;
      mem_wdata = wr_on_ff ? (mem_rdata | wr_mask_ff) : (mem_rdata & ~wr_mask_ff);
      case (state_ff)
         ST_WR_RD: begin
            mem_en = 1'b1;
         end
         ST_WR_WB: begin
            mem_en = 1'b1;
            mem_we = 1'b1;
         end
         ST_SCAN: begin
            mem_en   = issue;
            mem_addr = ADDR_W'(rd_line_ff * GRID_COLUMNS + pos_ff[POS_W-1:1]);
         end
         default: begin
            mem_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         acc_full_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_opcode == OP_SCAN_TICK) begin
                     state_ff   <= ST_SCAN;
                     rd_line_ff <= '0;
                  end else if (pix_ok) begin
                     state_ff <= ST_WR_RD;
                  end
               end
            end
            ST_WR_RD: begin
               state_ff <= ST_WR_WB;
            end
            ST_WR_WB: begin
               state_ff <= ST_IDLE;
            end
            ST_SCAN: begin
               if (scan_done) begin
                  state_ff <= ST_GRID;
               end
            end
            ST_GRID: begin
               if (grid_load) begin
                  state_ff <= ST_IDLE;
                  pos_ff   <= (pos_inc >= (POS_W + 1)'(POS_LIMIT)) ? '0 : pos_inc[POS_W-1:0];
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (accept) begin
            wr_addr_ff <= pix_addr;
            wr_mask_ff <= pix_mask;
            wr_on_ff   <= req_pixel_on;
         end

         rd_pend_ff <= issue;
         if (issue) begin
            rd_line_ff   <= rd_line_ff + 1'b1;
            pend_line_ff <= rd_line_ff[LINE_W-1:0];
         end

         // read data lands in the cycle after issue
         if (rd_pend_ff) begin
            acc_ff       <= acc_in;
            acc_chunk_ff <= CHUNK_W'(pend_line_ff >> 3);
         end
         if (rd_pend_ff && pend_last) begin
            acc_full_ff <= 1'b1;
         end else if (acc_move) begin
            acc_full_ff <= 1'b0;
         end

         if (acc_move) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff  <= acc_ff;
            rsp_chunk_ff <= acc_chunk_ff;
            rsp_last_ff  <= 1'b0;
         end else if (grid_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff  <= WORD_W'(2'b11) << pos_ff;
            rsp_chunk_ff <= CHUNK_W'(DATA_WORDS);
            rsp_last_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shift_word  = rsp_word_ff;
   assign rsp_chunk_index = rsp_chunk_ff;
   assign rsp_last_chunk  = rsp_last_ff;

endmodule

>>> hdl/vfd_grid_scan_framebuffer.sv
// Scan tick: one read a cycle from the single-port frame store while the result path does not
// stall, plus an idle read slot at each line group boundary.
// Pixel write: read, modify, write back; dropped if the line is out of range.
// One item at a time; results stall the scan while the output register is held.
// Reset: synchronous; a clearing pass zeroes all LINES*GRID_COLUMNS words (768 by default)
// ----------------------------------------------------------------------------
// vfd_grid_scan_framebuffer
// Frame store and grid scan sequencer for a multiplexed fluorescent tube.
// The clearing pass after reset zeroes the frame store while req_stall stays high.
// ----------------------------------------------------------------------------
module vfd_grid_scan_framebuffer
   import vgs_pkg::*;
#(
   parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
   parameter int LINES        = DEF_LINES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [X_W-1:0]     req_pixel_x,
   input  logic [Y_W-1:0]     req_pixel_y,
   input  logic               req_pixel_on,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [WORD_W-1:0]  rsp_shift_word,
   output logic [CHUNK_W-1:0] rsp_chunk_index,
   output logic               rsp_last_chunk
);

   localparam int DEPTH  = LINES * GRID_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [ADDR_W-1:0]          pix_addr;
   logic [BITS_PER_COLUMN-1:0] pix_mask;
   logic                       pix_ok;
   logic                       mem_en;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_addr;
   logic [BITS_PER_COLUMN-1:0] mem_wdata;
   logic [BITS_PER_COLUMN-1:0] mem_rdata;
   logic                       clear_busy;

   vgs_pixmap #(
      .GRID_COLUMNS (GRID_COLUMNS),
      .LINES        (LINES)
   ) u_pixmap (
      .pixel_x  (req_pixel_x),
      .pixel_y  (req_pixel_y),
      .pix_addr (pix_addr),
      .pix_mask (pix_mask),
      .pix_ok   (pix_ok)
   );

   vgs_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .mem_en     (mem_en),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata),
      .clear_busy (clear_busy)
   );

   vgs_ctrl #(
      .GRID_COLUMNS (GRID_COLUMNS),
      .LINES        (LINES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pixel_on    (req_pixel_on),
      .pix_addr        (pix_addr),
      .pix_mask        (pix_mask),
      .pix_ok          (pix_ok),
      .mem_en          (mem_en),
      .mem_we          (mem_we),
      .mem_addr        (mem_addr),
      .mem_wdata       (mem_wdata),
      .mem_rdata       (mem_rdata),
      .clear_busy      (clear_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_shift_word  (rsp_shift_word),
      .rsp_chunk_index (rsp_chunk_index),
      .rsp_last_chunk  (rsp_last_chunk)
   );

endmodule
